/* src/tep_pkg.sv */
// ----------------------------------------------------------------------------
// tep_pkg
// Shared types, widths and codes for the timer expiry queue.
// ----------------------------------------------------------------------------
package tep_pkg;

  localparam int unsigned TIMER_SLOTS_DEF = 32;
  localparam int unsigned TIME_W          = 63;
  localparam int unsigned IV_W            = 32;
  localparam int unsigned TAG_W           = 16;
  localparam int unsigned KIND_W          = 2;

  localparam logic [TIME_W-1:0] MIN_DELAY_US = TIME_W'(100);

  // request opcodes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_EXPIRE = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ADD_OK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_REJ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [IV_W-1:0]   interval;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // delay until expiry, clamped to the minimum
  function automatic logic [TIME_W-1:0] delay_calc(input logic [TIME_W-1:0] expiry,
                                                   input logic [TIME_W-1:0] now);
    logic [TIME_W:0] diff;
    diff = {1'b0, expiry} - {1'b0, now};
    if ((expiry > now) && (diff[TIME_W-1:0] >= MIN_DELAY_US)) begin
      return diff[TIME_W-1:0];
    end
    return MIN_DELAY_US;
  endfunction

endpackage

/* src/timer_expiry_queue.sv */
// ----------------------------------------------------------------------------
// timer_expiry_queue
// Table of pending timers in a slot memory; adds timers and fires due ones
// in expiry order, re-arming periodic timers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | opcode, now, expiry, interval, tag
//  out     | output    | out_valid_o/out_stall_i | kind, fired_tag, rearm, delay, last
//
//  One request at a time; every table pass reads one slot per cycle from the
//  slot memory. Add: one pass for the current minimum; a full table
//  answers without a pass. Expire with k due timers: one pass to mark the due
//  set, one select pass per fired timer (one even when none is due), one for
//  the next deadline, plus a fire step per fired timer and an emit step per
//  result.
//  Reset clears the valid bits at once; slot memory contents are not cleared.
//  A stalled result holds the sequencer in its emit step only.
// ----------------------------------------------------------------------------
module timer_expiry_queue #(
  parameter int unsigned TIMER_SLOTS = tep_pkg::TIMER_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [tep_pkg::TIME_W-1:0]  now_us_i,
  input  logic [tep_pkg::TIME_W-1:0]  expire_time_us_i,
  input  logic [tep_pkg::IV_W-1:0]    interval_us_i,
  input  logic [tep_pkg::TAG_W-1:0]   timer_tag_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tep_pkg::KIND_W-1:0]  kind_o,
  output logic [tep_pkg::TAG_W-1:0]   fired_tag_o,
  output logic                        rearm_o,
  output logic [tep_pkg::TIME_W-1:0]  arm_delay_us_o,
  output logic                        last_o
);
  import tep_pkg::*;

  localparam int unsigned IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CW-1:0] CNT_END = CW'(TIMER_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE, S_MARK, S_SEL, S_FIRE, S_FIN, S_ADD, S_EMIT
  } state_e;

  state_e state_q, state_d, nxt_q, nxt_d;

  // slot memory with a registered read port
  entry_t mem [TIMER_SLOTS];
  entry_t rd_q;
  logic   [IW-1:0] rd_addr;
  logic            mem_we;
  logic   [IW-1:0] mem_wa;
  entry_t          mem_wd;

  logic [TIMER_SLOTS-1:0] valid_q, valid_d, due_q, due_d;

  // scan engine
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              pv_q, pv_d;
  logic [IW-1:0]     pidx_q, pidx_d;
  logic              bf_q, bf_d;
  logic [IW-1:0]     bidx_q, bidx_d;
  logic [TIME_W-1:0] bexp_q, bexp_d;
  logic [IV_W-1:0]   biv_q, biv_d;
  logic [TAG_W-1:0]  btag_q, btag_d;

  // captured request
  logic [TIME_W-1:0] now_q, now_d, exp_q, exp_d;
  logic [IV_W-1:0]   iv_q, iv_d;
  logic [TAG_W-1:0]  tag_q, tag_d;

  // staged result and output register
  logic [KIND_W-1:0] rkind_q, rkind_d;
  logic [TAG_W-1:0]  rtag_q, rtag_d;
  logic              rrearm_q, rrearm_d, rlast_q, rlast_d;
  logic [TIME_W-1:0] rdly_q, rdly_d;
  logic              ov_q, ov_d;
  logic [KIND_W-1:0] okind_q, okind_d;
  logic [TAG_W-1:0]  otag_q, otag_d;
  logic              orearm_q, orearm_d, olast_q, olast_d;
  logic [TIME_W-1:0] odly_q, odly_d;

  logic              scan_done, cand, any_free, rem, first;
  logic [IW-1:0]     free_idx;
  logic [TIME_W:0]   rearm_sum;
  logic [TIME_W-1:0] rearm_exp;

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = ov_q;
  assign kind_o         = okind_q;
  assign fired_tag_o    = otag_q;
  assign rearm_o        = orearm_q;
  assign arm_delay_us_o = odly_q;
  assign last_o         = olast_q;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IW'(i);
    end
  end
  assign any_free = ~&valid_q;

  // saturating re-arm time
  assign rearm_sum = {1'b0, now_q} + {{(TIME_W + 1 - IV_W){1'b0}}, biv_q};
  assign rearm_exp = rearm_sum[TIME_W] ? {TIME_W{1'b1}} : rearm_sum[TIME_W-1:0];

  // due timers left after the current one
  always_comb begin
    rem = 1'b0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (due_q[i] && (IW'(i) != bidx_q)) rem = 1'b1;
    end
  end

  assign scan_done = (cnt_q == CNT_END) && !pv_q;
  assign rd_addr   = cnt_q[IW-1:0];
  assign first     = !bf_q || (exp_q < bexp_q);

  // sequencer
  always_comb begin
    state_d = state_q;   nxt_d = nxt_q;
    valid_d = valid_q;   due_d = due_q;
    cnt_d = cnt_q;       pv_d = pv_q;     pidx_d = pidx_q;
    bf_d = bf_q;         bidx_d = bidx_q; bexp_d = bexp_q;
    biv_d = biv_q;       btag_d = btag_q;
    now_d = now_q;       exp_d = exp_q;   iv_d = iv_q;  tag_d = tag_q;
    rkind_d = rkind_q;   rtag_d = rtag_q; rrearm_d = rrearm_q;
    rlast_d = rlast_q;   rdly_d = rdly_q;
    ov_d = ov_q;         okind_d = okind_q; otag_d = otag_q;
    orearm_d = orearm_q; olast_d = olast_q; odly_d = odly_q;
    mem_we = 1'b0;       mem_wa = bidx_q;
    mem_wd = '{expiry: rearm_exp, interval: biv_q, tag: btag_q};
    cand = 1'b0;

    if (ov_q && !out_stall_i) ov_d = 1'b0;

    // table pass: issue one read per cycle, process the returned data in the following cycle
    if (state_q == S_MARK || state_q == S_SEL || state_q == S_FIN || state_q == S_ADD) begin
      if (cnt_q < CNT_END) begin
        cnt_d  = cnt_q + 1'b1;
        pv_d   = 1'b1;
        pidx_d = cnt_q[IW-1:0];
      end else begin
        pv_d = 1'b0;
      end
      if (pv_q) begin
        unique case (state_q)
          S_MARK:  cand = 1'b0;
          S_SEL:   cand = due_q[pidx_q];
          default: cand = valid_q[pidx_q];
        endcase
        if (state_q == S_MARK) due_d[pidx_q] = valid_q[pidx_q] && (rd_q.expiry <= now_q);
        if (cand && (!bf_q || (rd_q.expiry < bexp_q))) begin
          bf_d   = 1'b1;
          bidx_d = pidx_q;
          bexp_d = rd_q.expiry;
          biv_d  = rd_q.interval;
          btag_d = rd_q.tag;
        end
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          now_d = now_us_i;  exp_d = expire_time_us_i;
          iv_d  = interval_us_i;  tag_d = timer_tag_i;
          cnt_d = '0;  pv_d = 1'b0;  bf_d = 1'b0;
          if (opcode_i == OP_EXPIRE) begin
            state_d = S_MARK;
          end else if (!any_free) begin
            rkind_d = KIND_ADD_REJ;  rtag_d = '0;  rrearm_d = 1'b0;
            rdly_d = '0;  rlast_d = 1'b1;
            nxt_d = S_IDLE;  state_d = S_EMIT;
          end else begin
            state_d = S_ADD;
          end
        end
      end
      S_MARK: begin
        if (scan_done) begin
          cnt_d = '0;  pv_d = 1'b0;  bf_d = 1'b0;
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        if (scan_done) begin
          if (bf_q) begin
            state_d = S_FIRE;
          end else begin
            rkind_d = KIND_NONE;  rtag_d = '0;
            cnt_d = '0;  pv_d = 1'b0;  bf_d = 1'b0;
            state_d = S_FIN;
          end
        end
      end
      S_FIRE: begin
        // write back the fired timer
        due_d[bidx_q] = 1'b0;
        if (biv_q != '0) mem_we = 1'b1;
        else valid_d[bidx_q] = 1'b0;
        rkind_d = KIND_FIRED;  rtag_d = btag_q;
        cnt_d = '0;  pv_d = 1'b0;  bf_d = 1'b0;
        if (rem) begin
          rrearm_d = 1'b0;  rdly_d = '0;  rlast_d = 1'b0;
          nxt_d = S_SEL;  state_d = S_EMIT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (scan_done) begin
          rrearm_d = bf_q;
          rdly_d   = bf_q ? delay_calc(bexp_q, now_q) : '0;
          rlast_d  = 1'b1;
          nxt_d = S_IDLE;  state_d = S_EMIT;
        end
      end
      S_ADD: begin
        if (scan_done) begin
          mem_we = 1'b1;  mem_wa = free_idx;
          mem_wd = '{expiry: exp_q, interval: iv_q, tag: tag_q};
          valid_d[free_idx] = 1'b1;
          rkind_d = KIND_ADD_OK;  rtag_d = '0;
          rrearm_d = first;
          rdly_d = first ? delay_calc(exp_q, now_q) : '0;
          rlast_d = 1'b1;
          nxt_d = S_IDLE;  state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;  okind_d = rkind_q;  otag_d = rtag_q;
          orearm_d = rrearm_q;  odly_d = rdly_q;  olast_d = rlast_q;
          state_d = nxt_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[rd_addr];
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;  nxt_q <= S_IDLE;
      valid_q <= '0;  due_q <= '0;
      cnt_q <= '0;  pv_q <= 1'b0;  pidx_q <= '0;
      bf_q <= 1'b0;  bidx_q <= '0;  bexp_q <= '0;  biv_q <= '0;  btag_q <= '0;
      now_q <= '0;  exp_q <= '0;  iv_q <= '0;  tag_q <= '0;
      rkind_q <= KIND_ADD_OK;  rtag_q <= '0;  rrearm_q <= 1'b0;
      rlast_q <= 1'b0;  rdly_q <= '0;
      ov_q <= 1'b0;  okind_q <= KIND_ADD_OK;  otag_q <= '0;
      orearm_q <= 1'b0;  olast_q <= 1'b0;  odly_q <= '0;
    end else begin
      state_q <= state_d;  nxt_q <= nxt_d;
      valid_q <= valid_d;  due_q <= due_d;
      cnt_q <= cnt_d;  pv_q <= pv_d;  pidx_q <= pidx_d;
      bf_q <= bf_d;  bidx_q <= bidx_d;  bexp_q <= bexp_d;  biv_q <= biv_d;  btag_q <= btag_d;
      now_q <= now_d;  exp_q <= exp_d;  iv_q <= iv_d;  tag_q <= tag_d;
      rkind_q <= rkind_d;  rtag_q <= rtag_d;  rrearm_q <= rrearm_d;
      rlast_q <= rlast_d;  rdly_q <= rdly_d;
      ov_q <= ov_d;  okind_q <= okind_d;  otag_q <= otag_d;
      orearm_q <= orearm_d;  olast_q <= olast_d;  odly_q <= odly_d;
    end
  end

endmodule

/* src/tep_checker.sv */
// ----------------------------------------------------------------------------
// tep_checker
// Port-level checks on the result stream of the timer expiry queue.
// ----------------------------------------------------------------------------
module tep_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [tep_pkg::KIND_W-1:0]  kind_o,
  input logic [tep_pkg::TAG_W-1:0]   fired_tag_o,
  input logic                        rearm_o,
  input logic [tep_pkg::TIME_W-1:0]  arm_delay_us_o,
  input logic                        last_o
);
  import tep_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(last_o))
    else $error("stalled result changed");

  // no rearm means no delay; rearm means at least the minimum
  a_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rearm_o ? (arm_delay_us_o >= MIN_DELAY_US) : (arm_delay_us_o == '0)))
    else $error("arm delay inconsistent with rearm");

  // only fired results carry a tag or continue
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_FIRED) |-> last_o && (fired_tag_o == '0))
    else $error("non-fire result not final or tagged");

  // a rejected add never reprograms the deadline
  a_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_ADD_REJ) |-> !rearm_o)
    else $error("rejected add requests rearm");

endmodule

bind timer_expiry_queue tep_checker u_tep_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_o         (kind_o),
  .fired_tag_o    (fired_tag_o),
  .rearm_o        (rearm_o),
  .arm_delay_us_o (arm_delay_us_o),
  .last_o         (last_o)
);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for timer_expiry_queue: a directed table of timer adds
// and expiries, a table fill and drain, then a random mix of monotonic-time
// traffic and noise. An in-bench timer table model predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tep_pkg::*;

  localparam int unsigned SLOTS      = TIMER_SLOTS_DEF;
  localparam int          RAND_ITEMS = 310;
  localparam longint      CYCLE_CAP  = 20_000_000;
  localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};

  typedef struct {
    logic              op;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] expt;
    logic [IV_W-1:0]   iv;
    logic [TAG_W-1:0]  tag;
  } timer_req_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic              rearm;
    logic [TIME_W-1:0] delay;
    logic              last;
  } timer_res_t;

  // directed row: request plus typed first result where obvious
  typedef struct {
    logic              op;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] expt;
    logic [IV_W-1:0]   iv;
    logic [TAG_W-1:0]  tag;
    bit                chk;
    logic [KIND_W-1:0] kind;
    logic              rearm;
    logic [TIME_W-1:0] delay;
  } dir_row_t;

  localparam int DIR_N = 14;
  dir_row_t dir_tab [0:DIR_N-1] = '{
    '{OP_EXPIRE, 0, 0, 0, 0, 1, KIND_NONE, 0, 0},
    '{OP_ADD, 0, 50, 0, 16'hFFFF, 1, KIND_ADD_OK, 1, 100},
    '{OP_ADD, 0, 1000, 0, 1, 1, KIND_ADD_OK, 0, 0},
    '{OP_ADD, 0, 50, 0, 2, 1, KIND_ADD_OK, 0, 0},
    '{OP_ADD, 0, TMAX, 32'hFFFF_FFFF, 0, 1, KIND_ADD_OK, 0, 0},
    '{OP_ADD, 0, 5000, 300, 3, 0, KIND_ADD_OK, 0, 0},
    '{OP_EXPIRE, 50, 0, 0, 0, 0, KIND_FIRED, 0, 0},
    '{OP_ADD, 100, 10, 0, 4, 1, KIND_ADD_OK, 1, 100},
    '{OP_ADD, 100, 299, 0, 5, 1, KIND_ADD_OK, 0, 0},
    '{OP_EXPIRE, 200, 0, 0, 0, 0, KIND_FIRED, 0, 0},
    '{OP_EXPIRE, 199, 0, 0, 0, 1, KIND_NONE, 1, 100},
    '{OP_EXPIRE, 5000, 0, 0, 0, 0, KIND_FIRED, 0, 0},
    '{OP_EXPIRE, TMAX - 50, 0, 0, 0, 0, KIND_FIRED, 0, 0},
    '{OP_EXPIRE, TMAX, 0, 0, 0, 0, KIND_FIRED, 0, 0}
  };

  // DUT signals
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              opcode_i = OP_ADD;
  logic [TIME_W-1:0] now_us_i = '0;
  logic [TIME_W-1:0] expire_time_us_i = '0;
  logic [IV_W-1:0]   interval_us_i = '0;
  logic [TAG_W-1:0]  timer_tag_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [KIND_W-1:0] kind_o;
  logic [TAG_W-1:0]  fired_tag_o;
  logic              rearm_o;
  logic [TIME_W-1:0] arm_delay_us_o;
  logic              last_o;

  timer_expiry_queue dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state: shadow timer table
  bit                mdl_valid [SLOTS];
  logic [TIME_W-1:0] mdl_expiry [SLOTS];
  logic [IV_W-1:0]   mdl_iv [SLOTS];
  logic [TAG_W-1:0]  mdl_tag [SLOTS];

  timer_res_t pending_res [$];
  int errors, n_items, n_fired, n_rejected, n_none, hold_seq, hold_seen;
  longint cycles;

  function automatic logic [TIME_W-1:0] time_to_fire(logic [TIME_W-1:0] ex,
                                                     logic [TIME_W-1:0] now);
    if (ex > now && (ex - now) >= MIN_DELAY_US) return ex - now;
    return MIN_DELAY_US;
  endfunction

  function automatic int soonest_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (mdl_valid[i] && (best < 0 || mdl_expiry[i] < mdl_expiry[best])) best = i;
    return best;
  endfunction

  // compute the results of one accepted request and queue them
  task automatic predict_timers(input timer_req_t rq, output timer_res_t first);
    int free_slot, e, best, n;
    bit due [SLOTS];
    timer_res_t r;
    logic [TIME_W:0] sum;
    free_slot = -1;
    n = 0;
    r = '{KIND_ADD_OK, 0, 0, 0, 1};
    if (rq.op == OP_ADD) begin
      for (int i = SLOTS - 1; i >= 0; i--) if (!mdl_valid[i]) free_slot = i;
      if (free_slot < 0) begin
        r.kind = KIND_ADD_REJ;
        n_rejected++;
      end else begin
        e = soonest_slot();
        if (e < 0 || rq.expt < mdl_expiry[e]) begin
          r.rearm = 1'b1;
          r.delay = time_to_fire(rq.expt, rq.now);
        end
        mdl_valid[free_slot]  = 1'b1;
        mdl_expiry[free_slot] = rq.expt;
        mdl_iv[free_slot]     = rq.iv;
        mdl_tag[free_slot]    = rq.tag;
      end
      pending_res.push_back(r);
      first = r;
    end else begin
      for (int i = 0; i < SLOTS; i++) due[i] = mdl_valid[i] && mdl_expiry[i] <= rq.now;
      forever begin
        best = -1;
        for (int i = 0; i < SLOTS; i++)
          if (due[i] && (best < 0 || mdl_expiry[i] < mdl_expiry[best])) best = i;
        if (best < 0) break;
        due[best] = 1'b0;
        r = '{KIND_FIRED, mdl_tag[best], 0, 0, 0};
        if (n == 0) first = r;
        pending_res.push_back(r);
        n++;
        n_fired++;
        if (mdl_iv[best] != 0) begin
          sum = {1'b0, rq.now} + mdl_iv[best];
          mdl_expiry[best] = sum[TIME_W] ? TMAX : sum[TIME_W-1:0];
        end else begin
          mdl_valid[best] = 1'b0;
        end
      end
      e = soonest_slot();
      if (n == 0) begin
        r = '{KIND_NONE, 0, 0, 0, 1};
        pending_res.push_back(r);
        n_none++;
      end
      r = pending_res[$];
      r.rearm = (e >= 0);
      r.delay = (e >= 0) ? time_to_fire(mdl_expiry[e], rq.now) : '0;
      r.last  = 1'b1;
      pending_res[$] = r;
      if (n == 0) first = r;
    end
  endtask

  // drive one request and wait for it to be taken
  task automatic offer_req(input timer_req_t rq, output timer_res_t first);
    in_valid_i       <= 1'b1;
    opcode_i         <= rq.op;
    now_us_i         <= rq.now;
    expire_time_us_i <= rq.expt;
    interval_us_i    <= rq.iv;
    timer_tag_i      <= rq.tag;
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
    predict_timers(rq, first);
  endtask

  // random idle between requests, mostly short
  task automatic sender_gap();
    int r, g;
    r = $urandom_range(0, 99);
    if (r < 40) g = 0;
    else if (r < 85) g = $urandom_range(1, 3);
    else if (r < 95) g = $urandom_range(4, 15);
    else g = $urandom_range(30, 150);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // result checker and receiver stall pattern
  int stall_left, quiet_left;
  always @(posedge clk_i) begin
    timer_res_t x;
    int r;
    if (out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result kind=%0d tag=%h", $time, kind_o, fired_tag_o);
        errors++;
      end else begin
        x = pending_res.pop_front();
        if (kind_o !== x.kind || fired_tag_o !== x.tag || rearm_o !== x.rearm ||
            arm_delay_us_o !== x.delay || last_o !== x.last) begin
          $display("%0t: mismatch expected kind=%0d tag=%h rearm=%b delay=%0d last=%b",
                   $time, x.kind, x.tag, x.rearm, x.delay, x.last);
          $display("%0t:          actual   kind=%0d tag=%h rearm=%b delay=%0d last=%b",
                   $time, kind_o, fired_tag_o, rearm_o, arm_delay_us_o, last_o);
          errors++;
        end
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen  = hold_seq;
      stall_left = 4000;
    end else if (stall_left == 0) begin
      if (quiet_left > 0) quiet_left--;
      else begin
        r = $urandom_range(0, 99);
        if (r < 2) stall_left = $urandom_range(30, 250);
        else if (r < 5) quiet_left = $urandom_range(100, 600);
        else if (r < 30) stall_left = $urandom_range(1, 3);
      end
    end
    out_stall_i <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timer_expiry_queue verification failed");
      $finish;
    end
  end

  initial begin
    timer_req_t rq;
    timer_res_t fr;
    logic [TIME_W-1:0] cur_time;
    int r;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_tab[i]) begin
      rq = '{dir_tab[i].op, dir_tab[i].now, dir_tab[i].expt, dir_tab[i].iv, dir_tab[i].tag};
      offer_req(rq, fr);
      if (dir_tab[i].chk && (fr.kind !== dir_tab[i].kind || fr.rearm !== dir_tab[i].rearm ||
          fr.delay !== dir_tab[i].delay)) begin
        $display("%0t: row %0d expected kind=%0d rearm=%b delay=%0d, model kind=%0d rearm=%b delay=%0d",
                 $time, i, dir_tab[i].kind, dir_tab[i].rearm, dir_tab[i].delay,
                 fr.kind, fr.rearm, fr.delay);
        errors++;
      end
      sender_gap();
    end

    // fill past capacity, then drain everything at the end of time
    for (int i = 0; i < SLOTS + 2; i++) begin
      rq = '{OP_ADD, 1000, TIME_W'($urandom_range(0, 100000)), 0, TAG_W'($urandom)};
      rq.now = 1000;
      offer_req(rq, fr);
      sender_gap();
    end
    rq = '{OP_EXPIRE, TMAX, 0, 0, 0};
    offer_req(rq, fr);
    sender_gap();

    // random traffic on a mostly advancing clock
    cur_time = TIME_W'($urandom_range(0, 1000));
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == 150) hold_seq++;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        rq = '{logic'($urandom), rand_time(), rand_time(), IV_W'($urandom), TAG_W'($urandom)};
      end else begin
        cur_time = cur_time + $urandom_range(0, 800);
        rq.now  = cur_time;
        rq.tag  = TAG_W'($urandom);
        rq.expt = rand_time();
        rq.iv   = IV_W'($urandom);
        if (r < 60) begin
          rq.op = OP_ADD;
          case ($urandom_range(0, 5))
            0: rq.expt = cur_time;
            1: rq.expt = cur_time - $urandom_range(0, 300);
            2: rq.expt = cur_time + $urandom_range(0, 150);
            default: rq.expt = cur_time + $urandom_range(0, 5000);
          endcase
          r = $urandom_range(0, 99);
          if (r < 80) rq.iv = '0;
          else if (r < 97) rq.iv = IV_W'($urandom_range(50, 3000));
        end else begin
          rq.op = OP_EXPIRE;
        end
      end
      offer_req(rq, fr);
      sender_gap();
    end
    in_valid_i <= 1'b0;

    wait (pending_res.size() == 0);
    repeat (1500) @(posedge clk_i);
    $display("Covered %0d requests: %0d timers fired, %0d adds rejected, %0d empty expiries.",
             n_items, n_fired, n_rejected, n_none);
    $display("Mismatches counted: %0d", errors);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("timer_expiry_queue verification clean");
    end else begin
      $display("timer_expiry_queue verification failed");
    end
    $finish;
  end

endmodule
